[hdl/wtz_pkg.sv]
// Package for the window table: sizes, operation codes, sequencer states
// and the id increment helper. No dependencies.
`timescale 1ns / 1ps
package wtz_pkg;
  localparam int WIN_NUM   = 16;
  localparam int SLOT_BITS = $clog2(WIN_NUM);
  localparam int CNT_BITS  = SLOT_BITS + 1;
  localparam int ID_BITS   = 16;
  localparam int DIM_BITS  = 16;
  localparam int POS_BITS  = 32;
  localparam logic [DIM_BITS-1:0] MAX_DIM_RESET = 16'd4096;

  typedef enum logic [2:0] {
    OP_CREATE  = 3'd0,
    OP_DESTROY = 3'd1,
    OP_RAISE   = 3'd2,
    OP_SET_GEO = 3'd3,
    OP_SET_MIN = 3'd4,
    OP_HIT     = 3'd5,
    OP_READ_Z  = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ALLOC,
    ST_FINDZ,
    ST_SHIFT,
    ST_HIT,
    ST_FINISH
  } state_t;

  function automatic logic [ID_BITS-1:0] bump_id(input logic [ID_BITS-1:0] v);
    logic [ID_BITS-1:0] n;
    n = v + 1'b1;
    return (n == '0) ? {{(ID_BITS-1){1'b0}}, 1'b1} : n;
  endfunction
endpackage

[hdl/wtz_in_if.sv]
// Request channel of the window table: valid/ready plus operation fields.
// Depends on wtz_pkg.
`timescale 1ns / 1ps
interface wtz_in_if;
  logic                             valid;
  logic                             ready;
  logic [2:0]                       operation;
  logic [wtz_pkg::ID_BITS-1:0]      window_id;
  logic signed [wtz_pkg::POS_BITS-1:0] pos_x;
  logic signed [wtz_pkg::POS_BITS-1:0] pos_y;
  logic [wtz_pkg::DIM_BITS-1:0]     size_w;
  logic [wtz_pkg::DIM_BITS-1:0]     size_h;
  logic                             flag_value;
  logic [3:0]                       z_index;

  modport source (output valid, operation, window_id, pos_x, pos_y, size_w, size_h,
                  flag_value, z_index, input ready);
  modport sink (input valid, operation, window_id, pos_x, pos_y, size_w, size_h,
                flag_value, z_index, output ready);
endinterface

[hdl/wtz_out_if.sv]
// Result channel of the window table: valid/ready plus result fields.
// Depends on wtz_pkg.
`timescale 1ns / 1ps
interface wtz_out_if;
  logic                          valid;
  logic                          ready;
  logic                          ok;
  logic [wtz_pkg::ID_BITS-1:0]   result_id;
  logic [wtz_pkg::CNT_BITS-1:0]  live_count;

  modport source (output valid, ok, result_id, live_count, input ready);
  modport sink (input valid, ok, result_id, live_count, output ready);
endinterface

[hdl/wtz_hit_unit.sv]
// Shared containment test: is a point within one window rectangle.
// Depends on wtz_pkg.
`timescale 1ns / 1ps
module wtz_hit_unit (
  input  logic signed [wtz_pkg::POS_BITS-1:0] px,
  input  logic signed [wtz_pkg::POS_BITS-1:0] py,
  input  logic signed [wtz_pkg::POS_BITS-1:0] ox,
  input  logic signed [wtz_pkg::POS_BITS-1:0] oy,
  input  logic [wtz_pkg::DIM_BITS-1:0]        w,
  input  logic [wtz_pkg::DIM_BITS-1:0]        h,
  output logic                                covered
);
  logic [wtz_pkg::POS_BITS:0] dx;
  logic [wtz_pkg::POS_BITS:0] dy;
  logic                       in_x;
  logic                       in_y;

  assign dx = {px[wtz_pkg::POS_BITS-1], px} - {ox[wtz_pkg::POS_BITS-1], ox};
  assign dy = {py[wtz_pkg::POS_BITS-1], py} - {oy[wtz_pkg::POS_BITS-1], oy};
  assign in_x = !dx[wtz_pkg::POS_BITS] &&
                (dx < {{(wtz_pkg::POS_BITS+1-wtz_pkg::DIM_BITS){1'b0}}, w});
  assign in_y = !dy[wtz_pkg::POS_BITS] &&
                (dy < {{(wtz_pkg::POS_BITS+1-wtz_pkg::DIM_BITS){1'b0}}, h});
  assign covered = in_x && in_y;
endmodule

[hdl/window_table_zorder_hit_test.sv]
// Window table with z-order list, id allocation and hit test.
// Id allocation tries one candidate a cycle, raise/destroy scan then shift the z list
// one entry a cycle, hit test walks the z list top down one entry a cycle through one
// containment unit.
// One operation at a time; the next is taken once the result is registered.
// Reset (rst, synchronous): table empty, next id 1, max dimension 4096.
`timescale 1ns / 1ps
module window_table_zorder_hit_test (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [wtz_pkg::DIM_BITS-1:0]   cfg_wr_data,
  wtz_in_if.sink                         in_ch,
  wtz_out_if.source                      out_ch
);
  localparam int N  = wtz_pkg::WIN_NUM;
  localparam int SB = wtz_pkg::SLOT_BITS;
  localparam int CB = wtz_pkg::CNT_BITS;
  localparam int IB = wtz_pkg::ID_BITS;
  localparam int DB = wtz_pkg::DIM_BITS;
  localparam int PB = wtz_pkg::POS_BITS;

  wtz_pkg::state_t state, state_next;

  logic [DB-1:0]        max_dim;
  logic [N-1:0]         used;
  logic [N-1:0]         hidden;
  logic [IB-1:0]        ident  [N];
  logic signed [PB-1:0] org_x  [N];
  logic signed [PB-1:0] org_y  [N];
  logic [DB-1:0]        wid    [N];
  logic [DB-1:0]        hgt    [N];
  logic [SB-1:0]        stack  [N];
  logic [CB-1:0]        total;
  logic [IB-1:0]        next_id;

  logic [2:0]           op;
  logic [IB-1:0]        op_id;
  logic signed [PB-1:0] op_x;
  logic signed [PB-1:0] op_y;
  logic [DB-1:0]        op_w;
  logic [DB-1:0]        op_h;
  logic                 op_flag;
  logic [3:0]           op_z;

  logic [SB-1:0]        slot;
  logic [CB-1:0]        idx;
  logic [IB-1:0]        cand;
  logic [CB-1:0]        tries;
  logic                 res_ok;
  logic [IB-1:0]        res_id;

  logic                 out_valid;
  logic                 out_ok;
  logic [IB-1:0]        out_id;
  logic [CB-1:0]        out_cnt;

  logic [IB-1:0]        key;
  logic [N-1:0]         match_vec;
  logic                 match_any;
  logic [SB-1:0]        match_idx;
  logic [SB-1:0]        free_idx;
  logic                 size_ok;
  logic [SB-1:0]        hit_slot;
  logic [SB-1:0]        readz_slot;
  logic                 covered;
  logic                 hit_now;
  logic                 out_free;
  logic                 readz_ok;

  wtz_hit_unit u_hit (
    .px(op_x), .py(op_y),
    .ox(org_x[hit_slot]), .oy(org_y[hit_slot]),
    .w(wid[hit_slot]), .h(hgt[hit_slot]),
    .covered(covered)
  );

  always_comb begin
    key = (state == wtz_pkg::ST_ALLOC) ? cand : op_id;
    match_any = 1'b0;
    match_idx = '0;
    free_idx  = '0;
    for (int k = N - 1; k >= 0; k--) begin
      match_vec[k] = used[k] && (ident[k] == key) && (key != '0);
      if (match_vec[k]) begin
        match_idx = SB'(k);
      end
      if (!used[k]) begin
        free_idx = SB'(k);
      end
    end
    match_any  = |match_vec;
    size_ok    = (op_w != '0) && (op_h != '0) && (op_w <= max_dim) && (op_h <= max_dim);
    hit_slot   = stack[SB'(idx - 1'b1)];
    readz_slot = stack[op_z[SB-1:0]];
    readz_ok   = CB'(op_z) < total;
    hit_now    = used[hit_slot] && !hidden[hit_slot] && covered;
    out_free   = !out_valid || out_ch.ready;
  end

  always_comb begin
    state_next = state;
    case (state)
      wtz_pkg::ST_IDLE: begin
        if (in_ch.valid) state_next = wtz_pkg::ST_DECODE;
      end
      wtz_pkg::ST_DECODE: begin
        state_next = wtz_pkg::ST_FINISH;
        case (op)
          wtz_pkg::OP_CREATE: begin
            if (total < CB'(N) && size_ok) state_next = wtz_pkg::ST_ALLOC;
          end
          wtz_pkg::OP_DESTROY, wtz_pkg::OP_RAISE: begin
            if (match_any) state_next = wtz_pkg::ST_FINDZ;
          end
          wtz_pkg::OP_HIT: begin
            if (total != '0) state_next = wtz_pkg::ST_HIT;
          end
          default: state_next = wtz_pkg::ST_FINISH;
        endcase
      end
      wtz_pkg::ST_ALLOC: begin
        if (!match_any || tries == CB'(N)) state_next = wtz_pkg::ST_FINISH;
      end
      wtz_pkg::ST_FINDZ: begin
        if (stack[idx[SB-1:0]] == slot) state_next = wtz_pkg::ST_SHIFT;
        else if (idx + 1'b1 >= total) state_next = wtz_pkg::ST_FINISH;
      end
      wtz_pkg::ST_SHIFT: begin
        if (idx >= total) state_next = wtz_pkg::ST_FINISH;
      end
      wtz_pkg::ST_HIT: begin
        if (hit_now || idx == CB'(1)) state_next = wtz_pkg::ST_FINISH;
      end
      wtz_pkg::ST_FINISH: begin
        if (out_free) state_next = wtz_pkg::ST_IDLE;
      end
      default: state_next = wtz_pkg::ST_IDLE;
    endcase
  end

  assign in_ch.ready       = (state == wtz_pkg::ST_IDLE);
  assign out_ch.valid      = out_valid;
  assign out_ch.ok         = out_ok;
  assign out_ch.result_id  = out_id;
  assign out_ch.live_count = out_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= wtz_pkg::ST_IDLE;
      max_dim   <= wtz_pkg::MAX_DIM_RESET;
      used      <= '0;
      hidden    <= '0;
      total     <= '0;
      next_id   <= {{(IB-1){1'b0}}, 1'b1};
      out_valid <= 1'b0;
      for (int k = 0; k < N; k++) begin
        ident[k] <= '0;
        org_x[k] <= '0;
        org_y[k] <= '0;
        wid[k]   <= '0;
        hgt[k]   <= '0;
        stack[k] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_wr_en) max_dim <= cfg_wr_data;
      if (state == wtz_pkg::ST_FINISH && out_free) out_valid <= 1'b1;
      else if (out_ch.ready) out_valid <= 1'b0;
      case (state)
        wtz_pkg::ST_IDLE: begin
          op      <= in_ch.operation;
          op_id   <= in_ch.window_id;
          op_x    <= in_ch.pos_x;
          op_y    <= in_ch.pos_y;
          op_w    <= in_ch.size_w;
          op_h    <= in_ch.size_h;
          op_flag <= in_ch.flag_value;
          op_z    <= in_ch.z_index;
        end
        wtz_pkg::ST_DECODE: begin
          slot   <= (op == wtz_pkg::OP_CREATE) ? free_idx : match_idx;
          idx    <= (op == wtz_pkg::OP_HIT) ? total : '0;
          res_ok <= ((op == wtz_pkg::OP_SET_GEO) && match_any && size_ok) ||
                    ((op == wtz_pkg::OP_SET_MIN) && match_any) ||
                    ((op == wtz_pkg::OP_READ_Z) && readz_ok);
          res_id <= ((op == wtz_pkg::OP_READ_Z) && readz_ok) ? ident[readz_slot] : '0;
          case (op)
            wtz_pkg::OP_CREATE: begin
              cand  <= (next_id == '0) ? {{(IB-1){1'b0}}, 1'b1} : next_id;
              tries <= '0;
            end
            wtz_pkg::OP_SET_GEO: begin
              if (match_any && size_ok) begin
                org_x[match_idx] <= op_x;
                org_y[match_idx] <= op_y;
                wid[match_idx]   <= op_w;
                hgt[match_idx]   <= op_h;
              end
            end
            wtz_pkg::OP_SET_MIN: begin
              if (match_any) begin
                hidden[match_idx] <= op_flag;
              end
            end
            default: ;
          endcase
        end
        wtz_pkg::ST_ALLOC: begin
          if (!match_any) begin
            used[slot]   <= 1'b1;
            hidden[slot] <= 1'b0;
            ident[slot]  <= cand;
            org_x[slot]  <= op_x;
            org_y[slot]  <= op_y;
            wid[slot]    <= op_w;
            hgt[slot]    <= op_h;
            stack[total[SB-1:0]] <= slot;
            total        <= total + 1'b1;
            next_id      <= wtz_pkg::bump_id(cand);
            res_ok       <= 1'b1;
            res_id       <= cand;
          end else begin
            cand  <= wtz_pkg::bump_id(cand);
            tries <= tries + 1'b1;
          end
        end
        wtz_pkg::ST_FINDZ: begin
          idx <= idx + 1'b1;
        end
        wtz_pkg::ST_SHIFT: begin
          if (idx < total) begin
            stack[SB'(idx - 1'b1)] <= stack[idx[SB-1:0]];
            idx <= idx + 1'b1;
          end else if (op == wtz_pkg::OP_DESTROY) begin
            total                      <= total - 1'b1;
            stack[SB'(total - 1'b1)]   <= '0;
            used[slot]                 <= 1'b0;
            hidden[slot]               <= 1'b0;
            ident[slot]                <= '0;
            org_x[slot]                <= '0;
            org_y[slot]                <= '0;
            wid[slot]                  <= '0;
            hgt[slot]                  <= '0;
            res_ok                     <= 1'b1;
          end else begin
            stack[SB'(total - 1'b1)] <= slot;
            res_ok                   <= 1'b1;
          end
        end
        wtz_pkg::ST_HIT: begin
          if (hit_now) begin
            res_ok <= 1'b1;
            res_id <= ident[hit_slot];
          end else begin
            idx <= idx - 1'b1;
          end
        end
        wtz_pkg::ST_FINISH: begin
          if (out_free) begin
            out_ok    <= res_ok;
            out_id    <= res_id;
            out_cnt   <= total;
          end
        end
        default: ;
      endcase
    end
  end

  a_total_bound: assert property (@(posedge clk) disable iff (rst) total <= CB'(N))
    else $error("live count above table size");
  a_total_used: assert property (@(posedge clk) disable iff (rst)
    $countones(used) == int'(total))
    else $error("live count disagrees with used slots");
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request taken while busy");
  a_next_id_nonzero: assert property (@(posedge clk) disable iff (rst) next_id != '0)
    else $error("next id is zero");
endmodule

[dv/tb_window_table_zorder_hit_test.sv]
// Testbench for window_table_zorder_hit_test: drives random and directed window operations.
// It checks every result against a scoreboard that keeps its own window table.
// Depends on wtz_pkg, wtz_in_if, wtz_out_if and the block itself.
`timescale 1ns / 1ps
module tb_window_table_zorder_hit_test;
  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic [2:0]                    operation;
    logic [wtz_pkg::ID_BITS-1:0]   window_id;
    logic signed [31:0]            pos_x;
    logic signed [31:0]            pos_y;
    logic [wtz_pkg::DIM_BITS-1:0]  size_w;
    logic [wtz_pkg::DIM_BITS-1:0]  size_h;
    logic                          flag_value;
    logic [3:0]                    z_index;
  } request_t;

  typedef struct {
    logic                          ok;
    logic [wtz_pkg::ID_BITS-1:0]   result_id;
    logic [wtz_pkg::CNT_BITS-1:0]  live_count;
  } answer_t;

  class window_ledger;
    bit                           used[wtz_pkg::WIN_NUM];
    logic [wtz_pkg::ID_BITS-1:0]  ident[wtz_pkg::WIN_NUM];
    longint                       org_x[wtz_pkg::WIN_NUM];
    longint                       org_y[wtz_pkg::WIN_NUM];
    longint                       wid[wtz_pkg::WIN_NUM];
    longint                       hgt[wtz_pkg::WIN_NUM];
    bit                           hidden[wtz_pkg::WIN_NUM];
    int                           stack[wtz_pkg::WIN_NUM];
    int                           total;
    logic [wtz_pkg::ID_BITS-1:0]  next_id;
    logic [wtz_pkg::DIM_BITS-1:0] max_dim;
    answer_t                      pending_answers[$];
    int                           errors;
    int                           created;
    int                           hits;
    int                           checked;

    function new();
      for (int i = 0; i < wtz_pkg::WIN_NUM; i++) begin
        used[i] = 0; ident[i] = '0; org_x[i] = 0; org_y[i] = 0;
        wid[i] = 0; hgt[i] = 0; hidden[i] = 0; stack[i] = 0;
      end
      total = 0;
      next_id = 1;
      max_dim = wtz_pkg::MAX_DIM_RESET;
      errors = 0; created = 0; hits = 0; checked = 0;
    endfunction

    function bit size_valid(logic [wtz_pkg::DIM_BITS-1:0] w,
                            logic [wtz_pkg::DIM_BITS-1:0] h);
      return w != 0 && h != 0 && w <= max_dim && h <= max_dim;
    endfunction

    function int slot_of(logic [wtz_pkg::ID_BITS-1:0] id);
      if (id == 0) return -1;
      for (int i = 0; i < wtz_pkg::WIN_NUM; i++)
        if (used[i] && ident[i] == id) return i;
      return -1;
    endfunction

    function int depth_of(int s);
      for (int z = 0; z < total; z++)
        if (stack[z] == s) return z;
      return -1;
    endfunction

    function logic [wtz_pkg::ID_BITS-1:0] next_after(logic [wtz_pkg::ID_BITS-1:0] v);
      logic [wtz_pkg::ID_BITS-1:0] n;
      n = v + 1;
      return (n == 0) ? 1 : n;
    endfunction

    function void unlink_depth(int z);
      for (int i = z + 1; i < total; i++) stack[i-1] = stack[i];
    endfunction

    function logic [wtz_pkg::ID_BITS-1:0] pick_live_id();
      int s;
      if (total == 0) return 0;
      s = stack[$urandom_range(0, total - 1)];
      return ident[s];
    endfunction

    function void edge_point(output logic signed [31:0] x, output logic signed [31:0] y);
      int s;
      longint dx;
      longint dy;
      s = stack[$urandom_range(0, total - 1)];
      case ($urandom_range(0, 3))
        0: dx = -1;
        1: dx = 0;
        2: dx = wid[s] - 1;
        default: dx = wid[s];
      endcase
      case ($urandom_range(0, 3))
        0: dy = -1;
        1: dy = 0;
        2: dy = hgt[s] - 1;
        default: dy = hgt[s];
      endcase
      x = org_x[s] + dx;
      y = org_y[s] + dy;
    endfunction

    function void note_request(request_t r);
      answer_t a;
      int s;
      int z;
      int k;
      logic [wtz_pkg::ID_BITS-1:0] cand;
      longint px;
      longint py;
      a.ok = 0;
      a.result_id = 0;
      px = r.pos_x;
      py = r.pos_y;
      case (r.operation)
        wtz_pkg::OP_CREATE: begin
          if (total < wtz_pkg::WIN_NUM && size_valid(r.size_w, r.size_h)) begin
            s = -1;
            for (int i = 0; i < wtz_pkg::WIN_NUM && s < 0; i++)
              if (!used[i]) s = i;
            cand = (next_id == 0) ? 1 : next_id;
            for (int t = 0; t <= wtz_pkg::WIN_NUM && !a.ok; t++) begin
              if (slot_of(cand) < 0) begin
                a.ok = 1;
                a.result_id = cand;
                next_id = next_after(cand);
              end else begin
                cand = next_after(cand);
              end
            end
            if (a.ok) begin
              used[s] = 1; ident[s] = a.result_id; hidden[s] = 0;
              org_x[s] = px; org_y[s] = py; wid[s] = r.size_w; hgt[s] = r.size_h;
              stack[total] = s;
              total++;
              created++;
            end
          end
        end
        wtz_pkg::OP_DESTROY: begin
          s = slot_of(r.window_id);
          if (s >= 0) begin
            z = depth_of(s);
            unlink_depth(z);
            total--;
            stack[total] = 0;
            used[s] = 0; ident[s] = 0; hidden[s] = 0;
            org_x[s] = 0; org_y[s] = 0; wid[s] = 0; hgt[s] = 0;
            a.ok = 1;
          end
        end
        wtz_pkg::OP_RAISE: begin
          s = slot_of(r.window_id);
          if (s >= 0) begin
            unlink_depth(depth_of(s));
            stack[total-1] = s;
            a.ok = 1;
          end
        end
        wtz_pkg::OP_SET_GEO: begin
          s = slot_of(r.window_id);
          if (s >= 0 && size_valid(r.size_w, r.size_h)) begin
            org_x[s] = px; org_y[s] = py; wid[s] = r.size_w; hgt[s] = r.size_h;
            a.ok = 1;
          end
        end
        wtz_pkg::OP_SET_MIN: begin
          s = slot_of(r.window_id);
          if (s >= 0) begin
            hidden[s] = r.flag_value;
            a.ok = 1;
          end
        end
        wtz_pkg::OP_HIT: begin
          for (int i = total; i > 0 && !a.ok; i--) begin
            k = stack[i-1];
            if (used[k] && !hidden[k] && px >= org_x[k] && py >= org_y[k] &&
                px - org_x[k] < wid[k] && py - org_y[k] < hgt[k]) begin
              a.ok = 1;
              a.result_id = ident[k];
              hits++;
            end
          end
        end
        wtz_pkg::OP_READ_Z: begin
          if (r.z_index < total) begin
            a.ok = 1;
            a.result_id = ident[stack[r.z_index]];
          end
        end
        default: ;
      endcase
      a.live_count = total;
      pending_answers.push_back(a);
    endfunction

    function void check_result(logic ok, logic [wtz_pkg::ID_BITS-1:0] id,
                               logic [wtz_pkg::CNT_BITS-1:0] cnt);
      answer_t a;
      checked++;
      if (pending_answers.size() == 0) begin
        $error("result transfer with nothing outstanding: ok=%0b id=%0d count=%0d",
               ok, id, cnt);
        errors++;
        return;
      end
      a = pending_answers.pop_front();
      if (ok !== a.ok) begin
        $error("ok: expected %0b, got %0b", a.ok, ok);
        errors++;
      end
      if (id !== a.result_id) begin
        $error("result_id: expected %0d, got %0d", a.result_id, id);
        errors++;
      end
      if (cnt !== a.live_count) begin
        $error("live_count: expected %0d, got %0d", a.live_count, cnt);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst;
  logic cfg_wr_en;
  logic [wtz_pkg::DIM_BITS-1:0] cfg_wr_data;
  wtz_in_if in_ch();
  wtz_out_if out_ch();
  window_ledger ledger = new();
  bit quiet = 0;
  int sent = 0;
  int idle_cycles = 0;
  int out_stall = 0;

  window_table_zorder_hit_test u_dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready)
      ledger.check_result(out_ch.ok, out_ch.result_id, out_ch.live_count);
    if (out_stall > 0) begin
      out_stall--;
      out_ch.ready <= 0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      out_stall = $urandom_range(0, 11);
      out_ch.ready <= 0;
    end else begin
      out_ch.ready <= 1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_wr_en)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_window_table_zorder_hit_test: errors");
      $finish;
    end
  end

  task automatic push_request(input request_t r);
    in_ch.valid <= 1;
    in_ch.operation <= r.operation;
    in_ch.window_id <= r.window_id;
    in_ch.pos_x <= r.pos_x;
    in_ch.pos_y <= r.pos_y;
    in_ch.size_w <= r.size_w;
    in_ch.size_h <= r.size_h;
    in_ch.flag_value <= r.flag_value;
    in_ch.z_index <= r.z_index;
    do @(posedge clk); while (!in_ch.ready);
    ledger.note_request(r);
    sent++;
    if (!quiet && $urandom_range(0, 6) == 0) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic write_max_dim(input logic [wtz_pkg::DIM_BITS-1:0] v);
    in_ch.valid <= 0;
    @(posedge clk);
    while (ledger.pending_answers.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_wr_en <= 1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 0;
    ledger.max_dim = v;
  endtask

  function automatic request_t make_request(logic [2:0] op,
                                            logic [wtz_pkg::ID_BITS-1:0] id,
                                            logic signed [31:0] x, logic signed [31:0] y,
                                            logic [wtz_pkg::DIM_BITS-1:0] w,
                                            logic [wtz_pkg::DIM_BITS-1:0] h,
                                            logic f, logic [3:0] z);
    request_t r;
    r.operation = op; r.window_id = id; r.pos_x = x; r.pos_y = y;
    r.size_w = w; r.size_h = h; r.flag_value = f; r.z_index = z;
    return r;
  endfunction

  function automatic logic [wtz_pkg::DIM_BITS-1:0] pick_size();
    int lim;
    lim = (ledger.max_dim < 100) ? ledger.max_dim : 100;
    case ($urandom_range(0, 19))
      0: return 0;
      1: return ledger.max_dim;
      2: return ledger.max_dim + 1;
      3: return $urandom;
      default: return (lim == 0) ? 0 : $urandom_range(1, lim);
    endcase
  endfunction

  function automatic request_t random_request(int create_weight);
    request_t r;
    int roll;
    r.window_id = ($urandom_range(0, 9) < 8) ? ledger.pick_live_id() : $urandom;
    r.pos_x = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 200) - 20;
    r.pos_y = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 200) - 20;
    r.size_w = pick_size();
    r.size_h = pick_size();
    r.flag_value = ($urandom_range(0, 3) == 0);
    r.z_index = $urandom;
    roll = $urandom_range(0, 99);
    if (roll < create_weight) r.operation = wtz_pkg::OP_CREATE;
    else if (roll < create_weight + 12) r.operation = wtz_pkg::OP_DESTROY;
    else if (roll < create_weight + 22) r.operation = wtz_pkg::OP_RAISE;
    else if (roll < create_weight + 32) r.operation = wtz_pkg::OP_SET_GEO;
    else if (roll < create_weight + 42) r.operation = wtz_pkg::OP_SET_MIN;
    else if (roll < create_weight + 44) r.operation = OP_UNUSED;
    else if (roll < create_weight + 54) r.operation = wtz_pkg::OP_READ_Z;
    else r.operation = wtz_pkg::OP_HIT;
    if (r.operation == wtz_pkg::OP_HIT && ledger.total > 0 && $urandom_range(0, 1) == 0)
      ledger.edge_point(r.pos_x, r.pos_y);
    return r;
  endfunction

  task automatic random_phase(input int count);
    int create_weight;
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) create_weight = $urandom_range(5, 40);
      if (sent > 1000) quiet = 1;
      push_request(random_request(create_weight));
    end
  endtask

  initial begin
    rst = 1;
    cfg_wr_en = 0;
    cfg_wr_data = '0;
    in_ch.valid = 0;
    in_ch.operation = '0;
    in_ch.window_id = '0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.size_w = '0;
    in_ch.size_h = '0;
    in_ch.flag_value = 0;
    in_ch.z_index = '0;
    out_ch.ready = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    push_request(make_request(wtz_pkg::OP_READ_Z, 0, 0, 0, 0, 0, 0, 0));
    push_request(make_request(wtz_pkg::OP_HIT, 0, 0, 0, 0, 0, 0, 0));
    push_request(make_request(wtz_pkg::OP_CREATE, 0, 0, 0, 10, 10, 0, 0));
    push_request(make_request(wtz_pkg::OP_CREATE, 0, 32'sh8000_0000, 32'sh7fff_ffff,
                              4096, 4096, 0, 0));
    push_request(make_request(wtz_pkg::OP_CREATE, 0, 0, 0, 4097, 5, 0, 0));
    push_request(make_request(wtz_pkg::OP_CREATE, 0, 0, 0, 0, 5, 0, 0));
    push_request(make_request(wtz_pkg::OP_CREATE, 0, 0, 0, 5, 0, 0, 0));
    push_request(make_request(wtz_pkg::OP_CREATE, 0, 5, 5, 10, 10, 1, 15));
    push_request(make_request(wtz_pkg::OP_HIT, 0, 5, 5, 0, 0, 0, 0));
    push_request(make_request(wtz_pkg::OP_HIT, 0, 14, 14, 0, 0, 0, 0));
    push_request(make_request(wtz_pkg::OP_HIT, 0, 15, 4, 0, 0, 0, 0));
    push_request(make_request(wtz_pkg::OP_HIT, 0, 32'sh8000_0000, 32'sh7fff_ffff,
                              0, 0, 0, 0));
    push_request(make_request(wtz_pkg::OP_HIT, 0, 32'sh8000_0fff, 32'sh7fff_ffff,
                              0, 0, 0, 0));
    push_request(make_request(wtz_pkg::OP_RAISE, 1, 0, 0, 0, 0, 0, 0));
    push_request(make_request(wtz_pkg::OP_HIT, 0, 6, 6, 0, 0, 0, 0));
    push_request(make_request(wtz_pkg::OP_SET_MIN, 1, 0, 0, 0, 0, 1, 0));
    push_request(make_request(wtz_pkg::OP_HIT, 0, 6, 6, 0, 0, 0, 0));
    push_request(make_request(wtz_pkg::OP_SET_GEO, 3, -50, -50, 1, 1, 0, 0));
    push_request(make_request(wtz_pkg::OP_SET_GEO, 3, 0, 0, 4097, 1, 0, 0));
    push_request(make_request(wtz_pkg::OP_READ_Z, 0, 0, 0, 0, 0, 0, 15));
    push_request(make_request(wtz_pkg::OP_READ_Z, 0, 0, 0, 0, 0, 0, 2));
    push_request(make_request(wtz_pkg::OP_DESTROY, 0, 0, 0, 0, 0, 0, 0));
    push_request(make_request(wtz_pkg::OP_DESTROY, 16'hffff, 0, 0, 0, 0, 0, 0));
    push_request(make_request(wtz_pkg::OP_DESTROY, 2, 0, 0, 0, 0, 0, 0));
    push_request(make_request(OP_UNUSED, 1, 0, 0, 1, 1, 1, 0));

    random_phase(280);
    write_max_dim(1);
    random_phase(200);
    write_max_dim(16'hffff);
    random_phase(220);
    write_max_dim($urandom_range(2, 300));
    random_phase(200);
    write_max_dim(wtz_pkg::MAX_DIM_RESET);
    random_phase(230);

    in_ch.valid <= 0;
    while (ledger.pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d operations sent, %0d results checked, %0d windows created, %0d hits",
             sent, ledger.checked, ledger.created, ledger.hits);
    $display("max dimension swept through 1, 65535, a random value and 4096");
    if (ledger.errors == 0 && ledger.pending_answers.size() == 0) begin
      $display("tb_window_table_zorder_hit_test: clean");
    end else begin
      $display("tb_window_table_zorder_hit_test: errors");
    end
    $finish;
  end
endmodule
